/* sv/cc20_pkg.sv */
// Shared types, constants and round function for the ChaCha20 keystream XOR unit
package cc20_pkg;

  localparam int DoubleRounds = 10;
  localparam int HalfSteps    = 4 * DoubleRounds;
  localparam int StepW        = $clog2(HalfSteps + 1);
  localparam int BlockBytes   = 64;
  localparam int BlockW       = 8 * BlockBytes;
  localparam int OffW         = $clog2(BlockBytes);
  localparam int InQueueDepth = 4;

  localparam logic [OffW-1:0] LastOff = OffW'(BlockBytes - 1);

  localparam logic [3:0][31:0] Sigma = {
    32'h6b206574, 32'h79622d32, 32'h3320646e, 32'h61707865
  };

  typedef enum logic [2:0] {
    CFG_KEY01   = 3'd0,
    CFG_KEY23   = 3'd1,
    CFG_KEY45   = 3'd2,
    CFG_KEY67   = 3'd3,
    CFG_NONCE01 = 3'd4,
    CFG_NONCE2  = 3'd5
  } cfg_idx_t;

  typedef enum logic {
    JOB_ZERO,
    JOB_PRE
  } job_t;

  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } item_t;

  typedef struct packed {
    logic [7:0][31:0] key;
    logic [2:0][31:0] nonce;
  } key_cfg_t;

  typedef struct packed {
    logic        start;
    logic        abort;
    logic [31:0] ctr;
  } gen_req_t;

  typedef struct packed {
    logic busy;
    logic done;
  } gen_sts_t;

  // half of a quarter round; returns {a, b, c, d}
  function automatic logic [127:0] qr_half(input logic [31:0] a, input logic [31:0] b,
                                           input logic [31:0] c, input logic [31:0] d,
                                           input logic second);
    logic [31:0] a2;
    logic [31:0] b2;
    logic [31:0] c2;
    logic [31:0] d2;
    a2 = a + b;
    d2 = d ^ a2;
    d2 = second ? {d2[23:0], d2[31:24]} : {d2[15:0], d2[31:16]};
    c2 = c + d2;
    b2 = b ^ c2;
    b2 = second ? {b2[24:0], b2[31:25]} : {b2[19:0], b2[31:20]};
    return {a2, b2, c2, d2};
  endfunction

endpackage

/* sv/chacha20_keystream_xor_unit.sv */
// Top level of the ChaCha20 keystream XOR unit
//
// Usage: write key and nonce through cfg_valid/cfg_ready/cfg_index/cfg_data
// (cfg_ready is always high; index 0..3 key word pairs, 4 nonce words 0/1,
// 5 nonce word 2). Push message bytes with in_push while in_full is low,
// in_last_byte set on the final byte of each message. Results come out in
// order: while out_empty is low the oldest result is on out_result_byte and
// out_result_last, and out_pop takes it.
// A pushed byte passes through the input queue and then the result queue
// before it shows on the result ports, once its keystream block is ready.
// Throughput: one byte per cycle while keystream blocks are ready and the
// result queue has room. The block function core builds each 64-byte block
// iteratively; the next block is built while the current one is used, and
// block zero stays cached so a new message starts at once. After reset, and
// after any register write, block zero is rebuilt before any byte that needs
// a new block goes through. Reset clears key and nonce, empties the queues.
// When the receiver stops popping, the 2-entry result queue and then the
// input queue fill and in_full rises; nothing is dropped.
module chacha20_keystream_xor_unit import cc20_pkg::*; #(
  parameter int IN_DEPTH = InQueueDepth
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_push,
  output logic        in_full,
  input  logic [7:0]  in_data_byte,
  input  logic        in_last_byte,
  output logic        out_empty,
  input  logic        out_pop,
  output logic [7:0]  out_result_byte,
  output logic        out_result_last,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [63:0] cfg_data
);

  logic [63:0]       key01_r;
  logic [63:0]       key23_r;
  logic [63:0]       key45_r;
  logic [63:0]       key67_r;
  logic [63:0]       nonce01_r;
  logic [31:0]       nonce2_r;
  logic              cfg_wr;
  key_cfg_t          kcfg;
  item_t             q_item;
  logic              q_valid;
  logic              q_take;
  gen_req_t          req;
  gen_sts_t          sts;
  logic [BlockW-1:0] blk;

  assign cfg_ready = 1'b1;
  assign cfg_wr    = cfg_valid && cfg_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      key01_r   <= '0;
      key23_r   <= '0;
      key45_r   <= '0;
      key67_r   <= '0;
      nonce01_r <= '0;
      nonce2_r  <= '0;
    end else if (cfg_wr) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_KEY01:   key01_r   <= cfg_data;
        CFG_KEY23:   key23_r   <= cfg_data;
        CFG_KEY45:   key45_r   <= cfg_data;
        CFG_KEY67:   key67_r   <= cfg_data;
        CFG_NONCE01: nonce01_r <= cfg_data;
        CFG_NONCE2:  nonce2_r  <= cfg_data[31:0];
        default: ;
      endcase
    end
  end

  assign kcfg.key   = {key67_r, key45_r, key23_r, key01_r};
  assign kcfg.nonce = {nonce2_r, nonce01_r};

  cc20_front #(
    .DEPTH(IN_DEPTH)
  ) u_front (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_push     (in_push),
    .in_data_byte(in_data_byte),
    .in_last_byte(in_last_byte),
    .in_full     (in_full),
    .q_item      (q_item),
    .q_valid     (q_valid),
    .q_take      (q_take)
  );

  cc20_core u_core (
    .clk  (clk),
    .rst_n(rst_n),
    .req  (req),
    .cfg  (kcfg),
    .sts  (sts),
    .blk  (blk)
  );

  cc20_back u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr         (cfg_wr),
    .q_item         (q_item),
    .q_valid        (q_valid),
    .q_take         (q_take),
    .req            (req),
    .sts            (sts),
    .blk            (blk),
    .out_empty      (out_empty),
    .out_pop        (out_pop),
    .out_result_byte(out_result_byte),
    .out_result_last(out_result_last)
  );

endmodule

/* sv/cc20_core.sv */
// Iterative ChaCha20 block function, in half quarter-round steps over columns and diagonals
module cc20_core import cc20_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  gen_req_t          req,
  input  key_cfg_t          cfg,
  output gen_sts_t          sts,
  output logic [BlockW-1:0] blk
);

  logic [31:0]      w_r [16];
  logic [31:0]      init [16];
  logic [31:0]      w_rnd [16];
  logic [StepW-1:0] step_r;
  logic             busy_r;
  logic             done_r;
  logic [31:0]      ctr_r;
  logic [31:0]      ctr_sel;
  logic             diag;
  logic             second;

  assign ctr_sel = req.start ? req.ctr : ctr_r;
  assign diag    = step_r[1];
  assign second  = step_r[0];

  always_comb begin
    for (int i = 0; i < 4; i++) begin
      init[i] = Sigma[i];
    end
    for (int i = 0; i < 8; i++) begin
      init[4+i] = cfg.key[i];
    end
    init[12] = ctr_sel;
    for (int i = 0; i < 3; i++) begin
      init[13+i] = cfg.nonce[i];
    end
  end

  always_comb begin
    logic [31:0]  a;
    logic [31:0]  b;
    logic [31:0]  c;
    logic [31:0]  d;
    logic [127:0] q;
    w_rnd = w_r;
    for (int i = 0; i < 4; i++) begin
      a = w_r[i];
      b = diag ? w_r[4 + ((i + 1) & 3)]  : w_r[4 + i];
      c = diag ? w_r[8 + ((i + 2) & 3)]  : w_r[8 + i];
      d = diag ? w_r[12 + ((i + 3) & 3)] : w_r[12 + i];
      q = qr_half(a, b, c, d, second);
      w_rnd[i] = q[127:96];
      if (diag) begin
        w_rnd[4 + ((i + 1) & 3)]  = q[95:64];
        w_rnd[8 + ((i + 2) & 3)]  = q[63:32];
        w_rnd[12 + ((i + 3) & 3)] = q[31:0];
      end else begin
        w_rnd[4 + i]  = q[95:64];
        w_rnd[8 + i]  = q[63:32];
        w_rnd[12 + i] = q[31:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
    end else begin
      done_r <= 1'b0;
      if (req.abort) begin
        busy_r <= 1'b0;
      end else if (req.start) begin
        busy_r <= 1'b1;
      end else if (busy_r && step_r == StepW'(HalfSteps)) begin
        busy_r <= 1'b0;
        done_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      step_r <= '0;
      ctr_r  <= req.ctr;
      w_r    <= init;
    end else if (busy_r) begin
      step_r <= step_r + 1'b1;
      if (step_r == StepW'(HalfSteps)) begin
        for (int k = 0; k < 16; k++) begin
          w_r[k] <= w_r[k] + init[k];
        end
      end else begin
        w_r <= w_rnd;
      end
    end
  end

  always_comb begin
    for (int k = 0; k < 16; k++) begin
      blk[32*k +: 32] = w_r[k];
    end
  end

  assign sts = '{busy: busy_r, done: done_r};

endmodule

/* sv/cc20_front.sv */
// Input side: accepts message bytes into a short queue toward the back end
module cc20_front import cc20_pkg::*; #(
  parameter int DEPTH = InQueueDepth
) (
  input  logic       clk,
  input  logic       rst_n,
  input  logic       in_push,
  input  logic [7:0] in_data_byte,
  input  logic       in_last_byte,
  output logic       in_full,
  output item_t      q_item,
  output logic       q_valid,
  input  logic       q_take
);

  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  item_t         mem_r [DEPTH];
  logic [AW-1:0] wp_r;
  logic [AW-1:0] rp_r;
  logic [CW-1:0] cnt_r;
  logic          push;
  logic          take;

  assign in_full = (cnt_r == CW'(DEPTH));
  assign q_valid = (cnt_r != '0);
  assign q_item  = mem_r[rp_r];
  assign push    = in_push && !in_full;
  assign take    = q_take && q_valid;

  always_ff @(posedge clk) begin
    if (push) begin
      mem_r[wp_r] <= '{data: in_data_byte, last: in_last_byte};
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (push) begin
        wp_r <= (wp_r == AW'(DEPTH - 1)) ? '0 : wp_r + 1'b1;
      end
      if (take) begin
        rp_r <= (rp_r == AW'(DEPTH - 1)) ? '0 : rp_r + 1'b1;
      end
      cnt_r <= cnt_r + CW'(push) - CW'(take);
    end
  end

endmodule

/* sv/cc20_back.sv */
// Back end: keystream block scheduling, byte XOR and result queue
module cc20_back import cc20_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              cfg_wr,
  input  item_t             q_item,
  input  logic              q_valid,
  output logic              q_take,
  output gen_req_t          req,
  input  gen_sts_t          sts,
  input  logic [BlockW-1:0] blk,
  output logic              out_empty,
  input  logic              out_pop,
  output logic [7:0]        out_result_byte,
  output logic              out_result_last
);

  logic [BlockW-1:0] cur_r;
  logic [BlockW-1:0] pre_r;
  logic [BlockW-1:0] zero_r;
  logic              cur_vld_r;
  logic              pre_vld_r;
  logic              zero_vld_r;
  logic [31:0]       cur_ctr_r;
  logic [31:0]       pre_ctr_r;
  logic [31:0]       job_ctr_r;
  job_t              job_r;
  logic [OffW-1:0]   off_r;

  logic [7:0]        oq_byte_r [2];
  logic              oq_last_r [2];
  logic              oq_wp_r;
  logic              oq_rp_r;
  logic [1:0]        oq_cnt_r;

  logic [31:0]       want;
  logic              pre_ok;
  logic              need_pre;
  logic              consume;
  logic              pop_fire;

  assign want     = cur_vld_r ? cur_ctr_r + 1'b1 : cur_ctr_r;
  assign pre_ok   = pre_vld_r && (pre_ctr_r == want);
  assign need_pre = !pre_ok && (cur_vld_r || cur_ctr_r != '0);
  assign consume  = q_valid && cur_vld_r && (oq_cnt_r != 2'd2);
  assign q_take   = consume;
  assign pop_fire = out_pop && !out_empty;

  always_comb begin
    req.start = !sts.busy && !sts.done && !cfg_wr && (!zero_vld_r || need_pre);
    req.ctr   = zero_vld_r ? want : '0;
    req.abort = cfg_wr || (sts.busy && job_r == JOB_PRE && job_ctr_r != want);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      job_r     <= JOB_ZERO;
      job_ctr_r <= '0;
    end else if (req.start) begin
      job_r     <= zero_vld_r ? JOB_PRE : JOB_ZERO;
      job_ctr_r <= req.ctr;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cur_vld_r  <= 1'b0;
      pre_vld_r  <= 1'b0;
      zero_vld_r <= 1'b0;
      cur_ctr_r  <= '0;
      pre_ctr_r  <= '0;
      off_r      <= '0;
    end else begin
      if (pre_vld_r && pre_ctr_r != want) begin
        pre_vld_r <= 1'b0;
      end
      if (consume) begin
        if (q_item.last) begin
          cur_r     <= zero_r;
          cur_vld_r <= zero_vld_r;
          cur_ctr_r <= '0;
          off_r     <= '0;
        end else if (off_r == LastOff) begin
          off_r     <= '0;
          cur_ctr_r <= cur_ctr_r + 1'b1;
          if (pre_ok) begin
            cur_r     <= pre_r;
            pre_vld_r <= 1'b0;
          end else begin
            cur_vld_r <= 1'b0;
          end
        end else begin
          cur_r <= cur_r >> 8;
          off_r <= off_r + 1'b1;
        end
      end else if (!cur_vld_r) begin
        if (cur_ctr_r == '0 && zero_vld_r) begin
          cur_r     <= zero_r;
          cur_vld_r <= 1'b1;
        end else if (pre_ok) begin
          cur_r     <= pre_r;
          cur_vld_r <= 1'b1;
          pre_vld_r <= 1'b0;
        end
      end
      if (sts.done && !cfg_wr) begin
        if (job_r == JOB_ZERO) begin
          zero_r     <= blk;
          zero_vld_r <= 1'b1;
        end else if (job_ctr_r == want) begin
          pre_r     <= blk;
          pre_vld_r <= 1'b1;
          pre_ctr_r <= job_ctr_r;
        end
      end
      // drop cached blocks; an untouched current block is rebuilt too
      if (cfg_wr) begin
        zero_vld_r <= 1'b0;
        pre_vld_r  <= 1'b0;
        if (off_r == '0) begin
          cur_vld_r <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (consume) begin
      oq_byte_r[oq_wp_r] <= q_item.data ^ cur_r[7:0];
      oq_last_r[oq_wp_r] <= q_item.last;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      oq_wp_r  <= 1'b0;
      oq_rp_r  <= 1'b0;
      oq_cnt_r <= '0;
    end else begin
      if (consume) begin
        oq_wp_r <= !oq_wp_r;
      end
      if (pop_fire) begin
        oq_rp_r <= !oq_rp_r;
      end
      oq_cnt_r <= oq_cnt_r + 2'(consume) - 2'(pop_fire);
    end
  end

  assign out_empty       = (oq_cnt_r == '0);
  assign out_result_byte = oq_byte_r[oq_rp_r];
  assign out_result_last = oq_last_r[oq_rp_r];

endmodule

/* dv/chacha20_keystream_xor_unit_test.sv */
// Self-checking testbench for the ChaCha20 keystream XOR unit
`timescale 1ns / 1ps

module chacha20_keystream_xor_unit_test;
  import cc20_pkg::*;

  localparam logic [2:0] CfgIdxSpare  = 3'd6;
  localparam logic [2:0] CfgIdxTop    = 3'd7;
  localparam int         SettleCycles = 100;
  localparam int         HoldCycles   = 300;
  localparam int         TargetBytes  = 1650;

  typedef struct packed {
    logic [7:0] byte_val;
    logic       last;
  } cipher_out_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_push = 1'b0;
  logic        in_full;
  logic [7:0]  in_data_byte = 8'h00;
  logic        in_last_byte = 1'b0;
  logic        out_empty;
  logic        out_pop = 1'b0;
  logic [7:0]  out_result_byte;
  logic        out_result_last;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [2:0]  cfg_index = 3'd0;
  logic [63:0] cfg_data = 64'h0;

  chacha20_keystream_xor_unit DUT (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_push         (in_push),
    .in_full         (in_full),
    .in_data_byte    (in_data_byte),
    .in_last_byte    (in_last_byte),
    .out_empty       (out_empty),
    .out_pop         (out_pop),
    .out_result_byte (out_result_byte),
    .out_result_last (out_result_last),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // shadow of the key/nonce registers and the keystream position
  logic [63:0] shadow_reg [6];
  logic [31:0] blk_ctr;
  logic [5:0]  ks_offset;
  logic [7:0]  keystream [64];

  item_t       pending [$];
  cipher_out_t cipher_q [$];
  cipher_out_t want;

  int  errors = 0;
  int  queued = 0;
  int  bytes_sent = 0;
  int  msgs_sent = 0;
  int  reg_writes = 0;
  int  blocks_made = 0;
  int  push_gap = 0;
  int  pop_gap = 0;
  bit  send_idle = 1'b0;
  bit  recv_idle = 1'b0;
  bit  hold_req = 1'b0;
  logic rx_hold = 1'b0;

  function automatic logic [127:0] quarter(logic [31:0] a, logic [31:0] b,
                                           logic [31:0] c, logic [31:0] d);
    a += b; d ^= a; d = {d[15:0], d[31:16]};
    c += d; b ^= c; b = {b[19:0], b[31:20]};
    a += b; d ^= a; d = {d[23:0], d[31:24]};
    c += d; b ^= c; b = {b[24:0], b[31:25]};
    return {a, b, c, d};
  endfunction

  function automatic void refill_keystream();
    logic [31:0]  init [16];
    logic [31:0]  w [16];
    logic [127:0] q;
    logic [31:0]  v;
    int ia, ib, ic, id;
    init[0]  = 32'h61707865;
    init[1]  = 32'h3320646e;
    init[2]  = 32'h79622d32;
    init[3]  = 32'h6b206574;
    for (int k = 0; k < 4; k++) begin
      init[4 + 2 * k] = shadow_reg[k][31:0];
      init[5 + 2 * k] = shadow_reg[k][63:32];
    end
    init[12] = blk_ctr;
    init[13] = shadow_reg[CFG_NONCE01][31:0];
    init[14] = shadow_reg[CFG_NONCE01][63:32];
    init[15] = shadow_reg[CFG_NONCE2][31:0];
    for (int i = 0; i < 16; i++) w[i] = init[i];
    for (int r = 0; r < 10; r++) begin
      for (int pass = 0; pass < 2; pass++) begin
        for (int k = 0; k < 4; k++) begin
          ia = k;
          ib = 4 + ((k + pass) % 4);
          ic = 8 + ((k + 2 * pass) % 4);
          id = 12 + ((k + 3 * pass) % 4);
          q = quarter(w[ia], w[ib], w[ic], w[id]);
          w[ia] = q[127:96];
          w[ib] = q[95:64];
          w[ic] = q[63:32];
          w[id] = q[31:0];
        end
      end
    end
    for (int i = 0; i < 16; i++) begin
      v = w[i] + init[i];
      for (int j = 0; j < 4; j++) keystream[4 * i + j] = v[8 * j +: 8];
    end
    blocks_made++;
  endfunction

  function automatic cipher_out_t encrypt_byte(item_t it);
    cipher_out_t r;
    if (ks_offset == 6'd0) begin
      refill_keystream();
      blk_ctr = blk_ctr + 32'd1;
    end
    r.byte_val = it.data ^ keystream[ks_offset];
    r.last     = it.last;
    ks_offset  = ks_offset + 6'd1;
    if (it.last) begin
      blk_ctr   = 32'd0;
      ks_offset = 6'd0;
    end
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    r = $urandom_range(99);
    if (r < 50) return 0;
    if (r < 85) return $urandom_range(3, 1);
    if (r < 97) return $urandom_range(12, 4);
    return $urandom_range(60, 20);
  endfunction

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_push <= 1'b0;
    end else begin
      if (in_push && !in_full) begin
        if (pending[0].last) msgs_sent++;
        cipher_q.push_back(encrypt_byte(pending.pop_front()));
        bytes_sent++;
        push_gap = send_idle ? pick_gap() : 0;
      end
      if (!(in_push && in_full)) begin
        if (push_gap > 0) begin
          push_gap--;
          in_push <= 1'b0;
        end else if (pending.size() > 0) begin
          in_push      <= 1'b1;
          in_data_byte <= pending[0].data;
          in_last_byte <= pending[0].last;
        end else begin
          in_push <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin
    if (!rst_n) begin
      out_pop <= 1'b0;
    end else begin
      if (out_pop && !out_empty) begin
        if (cipher_q.size() == 0) begin
          $error("unexpected item: result_byte %h result_last %b",
                 out_result_byte, out_result_last);
          errors++;
        end else begin
          want = cipher_q.pop_front();
          if (out_result_byte !== want.byte_val) begin
            $error("result_byte: expected %h, actual %h", want.byte_val, out_result_byte);
            errors++;
          end
          if (out_result_last !== want.last) begin
            $error("result_last: expected %b, actual %b", want.last, out_result_last);
            errors++;
          end
        end
        pop_gap = recv_idle ? pick_gap() : 0;
      end
      if (rx_hold) begin
        out_pop <= 1'b0;
      end else if (pop_gap > 0) begin
        pop_gap--;
        out_pop <= 1'b0;
      end else begin
        out_pop <= 1'b1;
      end
    end
  end

  // long receiver hold-off to back up the block
  initial begin
    wait (hold_req);
    @(posedge clk);
    rx_hold <= 1'b1;
    repeat (HoldCycles) @(posedge clk);
    rx_hold <= 1'b0;
  end

  task automatic add_byte(logic [7:0] d, logic l);
    item_t t;
    t.data = d;
    t.last = l;
    pending.push_back(t);
    queued++;
  endtask

  task automatic add_message(int len);
    for (int j = 0; j < len; j++) add_byte(8'($urandom), j == len - 1);
  endtask

  task automatic settle();
    while (pending.size() != 0 || cipher_q.size() != 0 || in_push) @(posedge clk);
    repeat (SettleCycles) @(posedge clk);
  endtask

  task automatic write_reg(logic [2:0] idx, logic [63:0] val);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx <= CFG_NONCE2) begin
      shadow_reg[idx] = (idx == CFG_NONCE2) ? {32'h0, val[31:0]} : val;
    end
    reg_writes++;
    cfg_valid <= 1'b0;
  endtask

  task automatic load_all(logic [63:0] val);
    write_reg(CFG_KEY01, val);
    write_reg(CFG_KEY23, val);
    write_reg(CFG_KEY45, val);
    write_reg(CFG_KEY67, val);
    write_reg(CFG_NONCE01, val);
    write_reg(CFG_NONCE2, val);
  endtask

  initial begin
    int phase;
    for (int k = 0; k < 6; k++) shadow_reg[k] = 64'h0;
    blk_ctr   = 32'd0;
    ks_offset = 6'd0;
    repeat (6) @(posedge clk);
    rst_n <= 1'b1;

    // all-zero key and nonce from reset
    add_byte(8'h00, 1'b0);
    add_byte(8'hFF, 1'b0);
    add_byte(8'hA5, 1'b0);
    add_byte(8'h5A, 1'b1);
    add_byte(8'hFF, 1'b1);
    add_byte(8'h00, 1'b1);
    settle();

    // all-ones registers, unused indexes must not disturb them
    load_all('1);
    write_reg(CfgIdxSpare, 64'h0);
    write_reg(CfgIdxTop, {$urandom, $urandom});
    add_byte(8'hFF, 1'b0);
    add_byte(8'h00, 1'b0);
    add_byte(8'h3C, 1'b1);
    add_byte(8'hC3, 1'b1);
    settle();

    // write in the middle of a message: held block stays in use
    add_byte(8'h11, 1'b0);
    add_byte(8'h22, 1'b0);
    settle();
    write_reg(CFG_KEY67, {$urandom, $urandom});
    add_byte(8'h33, 1'b0);
    add_byte(8'h44, 1'b1);
    add_byte(8'h80, 1'b0);
    add_byte(8'h01, 1'b1);
    settle();

    phase = 0;
    while (queued < TargetBytes) begin
      send_idle = ($urandom_range(3) != 0);
      recv_idle = ($urandom_range(3) != 0);
      case ($urandom_range(9))
        0: load_all('0);
        1: load_all('1);
        2: write_reg(CFG_NONCE2, {$urandom, $urandom});
        default: repeat ($urandom_range(3)) write_reg(3'($urandom_range(CfgIdxTop, 0)),
                                                      {$urandom, $urandom});
      endcase
      if (phase == 3) begin
        send_idle = 1'b0;
        recv_idle = 1'b0;
        hold_req  = 1'b1;
        add_message(90);
      end
      repeat ($urandom_range(4, 1)) begin
        if ($urandom_range(9) == 0) add_message($urandom_range(200, 64));
        else add_message($urandom_range(70, 1));
      end
      // leave a message open across the next register write
      if ($urandom_range(4) == 0) begin
        repeat ($urandom_range(20, 1)) add_byte(8'($urandom), 1'b0);
      end
      settle();
      phase++;
    end

    $display("Run covered %0d bytes in %0d messages over %0d phases,", bytes_sent,
             msgs_sent, phase);
    $display("%0d register writes and %0d keystream blocks.", reg_writes, blocks_made);
    if (errors == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #10_000_000;
    $display("timeout with %0d items outstanding", cipher_q.size() + pending.size());
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule
